// ----- src/bta_pkg.sv -----
// Shared types and codes for the binary tree event arbiter.
// Item structs, request and answer codes and field widths; no dependencies.
`default_nettype none
package bta_pkg;

	localparam int ADDRESS_BITS_DEF = 12;
	localparam int KIND_W  = 3;
	localparam int LEVEL_W = 4;
	localparam int ADDR_W  = 12;
	localparam int COUNT_W = 16;

	localparam logic [KIND_W-1:0] KIND_GENERAL = 3'd0;
	localparam logic [KIND_W-1:0] KIND_GROUP   = 3'd1;
	localparam logic [KIND_W-1:0] KIND_SINGLE  = 3'd2;
	localparam logic [KIND_W-1:0] KIND_READ    = 3'd3;
	localparam logic [KIND_W-1:0] KIND_DONE    = 3'd4;
	localparam logic [KIND_W-1:0] KIND_IDLE    = 3'd5;

	localparam logic ACT_START  = 1'b0;
	localparam logic ACT_ANSWER = 1'b1;

	localparam logic [1:0] ANS_NONE    = 2'd0;
	localparam logic [1:0] ANS_ONE     = 2'd1;
	localparam logic [1:0] ANS_SEVERAL = 2'd2;

	typedef struct packed {
		logic       action;
		logic [1:0] answer;
	} in_item_t;

	typedef struct packed {
		logic [KIND_W-1:0]  request_kind;
		logic [LEVEL_W-1:0] level;
		logic [ADDR_W-1:0]  address;
		logic [COUNT_W-1:0] message_count;
	} out_item_t;

	// Run state that does not depend on the address width.
	typedef struct packed {
		logic [KIND_W-1:0]  last_kind;
		logic               tree_active;
		logic [COUNT_W-1:0] read_count;
	} ctl_t;

endpackage
`default_nettype wire

// ----- src/binary_tree_event_arbiter_core.sv -----
// Binary tree event arbiter: turns each partner answer into the next request.
// An accepted item waits in the input register; its result is registered at the output.
// Throughput: one item per cycle unless the output stalls; the answer held in the
// input register and the run state are resolved combinationally by bta_step.
// Reset: the tree is empty, the count and target are zero and the last request is idle.
`default_nettype none
module binary_tree_event_arbiter_core #(
	parameter int ADDRESS_BITS = bta_pkg::ADDRESS_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  bta_pkg::in_item_t           in_data,
	output logic                        out_valid,
	input  logic                        out_ready,
	output bta_pkg::out_item_t          out_data,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [bta_pkg::COUNT_W-1:0] cfg_data
);
	import bta_pkg::*;

	localparam int LVL_W = $clog2(ADDRESS_BITS);

	logic                     valid_s1;
	in_item_t                 item_s1;
	logic                     out_valid_q;
	out_item_t                out_data_q;
	logic [COUNT_W-1:0]       target_q;
	ctl_t                     ctl_q;
	logic [LVL_W-1:0]         top_q;
	logic [ADDRESS_BITS-1:0]  phase_q;
	logic                     step_en;
	out_item_t                result;
	ctl_t                     ctl_d;
	logic [LVL_W-1:0]         top_d;
	logic [ADDRESS_BITS-1:0]  phase_d;

	assign step_en   = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready  = !valid_s1 || step_en;
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	bta_step #(
		.ADDRESS_BITS(ADDRESS_BITS),
		.LVL_W       (LVL_W)
	) u_step (
		.item   (item_s1),
		.ctl_q  (ctl_q),
		.top_q  (top_q),
		.phase_q(phase_q),
		.target (target_q),
		.result (result),
		.ctl_d  (ctl_d),
		.top_d  (top_d),
		.phase_d(phase_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1          <= 1'b0;
			out_valid_q       <= 1'b0;
			target_q          <= '0;
			ctl_q.last_kind   <= KIND_IDLE;
			ctl_q.tree_active <= 1'b0;
			ctl_q.read_count  <= '0;
			top_q             <= '0;
			phase_q           <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				target_q <= cfg_data;
			end
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (step_en) begin
				out_valid_q <= 1'b1;
				ctl_q       <= ctl_d;
				top_q       <= top_d;
				phase_q     <= phase_d;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_data;
		end
		if (step_en) begin
			out_data_q <= result;
		end
	end

	// Outside a tree the level pointer always rests at the bottom.
	a_top_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!ctl_q.tree_active |-> top_q == '0)
		else $error("level pointer not cleared outside a tree");

	a_top_range: assert property (@(posedge clk) disable iff (!arst_n)
		32'(top_q) < ADDRESS_BITS)
		else $error("level pointer beyond the address width");

	// Only group requests carry a level, and never level zero.
	a_group_level: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> ((out_data_q.request_kind == KIND_GROUP) == (out_data_q.level != '0)))
		else $error("request level does not match request kind");

	// A start item always yields a fresh run with a cleared count.
	a_start_clears: assert property (@(posedge clk) disable iff (!arst_n)
		step_en && item_s1.action == ACT_START |=> out_data_q.message_count == '0)
		else $error("start item did not clear the message count");

endmodule
`default_nettype wire

// ----- src/bta_step.sv -----
// Next-state and request logic for one partner answer of the arbiter.
// Purely combinational; depends on bta_pkg.
`default_nettype none
module bta_step #(
	parameter int ADDRESS_BITS = bta_pkg::ADDRESS_BITS_DEF,
	parameter int LVL_W = $clog2(ADDRESS_BITS)
) (
	input  bta_pkg::in_item_t          item,
	input  bta_pkg::ctl_t              ctl_q,
	input  logic [LVL_W-1:0]           top_q,
	input  logic [ADDRESS_BITS-1:0]    phase_q,
	input  logic [bta_pkg::COUNT_W-1:0] target,
	output bta_pkg::out_item_t         result,
	output bta_pkg::ctl_t              ctl_d,
	output logic [LVL_W-1:0]           top_d,
	output logic [ADDRESS_BITS-1:0]    phase_d
);
	import bta_pkg::*;

	logic               adv_found;
	logic [LVL_W-1:0]   adv_lvl;
	logic [COUNT_W-1:0] cnt_inc;
	logic [COUNT_W-1:0] cnt_next;
	logic               do_finish;
	logic               do_advance;
	logic               do_push;
	logic               do_read;
	logic               do_idle;
	logic               set_tree;
	logic [LVL_W-1:0]   push_lvl;
	logic [LVL_W-1:0]   child_lvl;
	logic [ADDR_W-1:0]  child_addr;
	logic [KIND_W-1:0]  kind;

	assign cnt_inc = (ctl_q.read_count == '1) ? ctl_q.read_count
		: ctl_q.read_count + COUNT_W'(1);

	// The walk resumes at the nearest level at or above the current one whose
	// second branch has not yet been taken.
	always_comb begin
		adv_found = 1'b0;
		adv_lvl   = top_q;
		for (int j = ADDRESS_BITS - 1; j >= 0; j--) begin
			if (LVL_W'(j) >= top_q && !phase_q[j]) begin
				adv_found = 1'b1;
				adv_lvl   = LVL_W'(j);
			end
		end
	end

	always_comb begin
		do_finish  = 1'b0;
		do_advance = 1'b0;
		do_push    = 1'b0;
		do_read    = 1'b0;
		do_idle    = 1'b0;
		set_tree   = 1'b0;
		push_lvl   = LVL_W'(ADDRESS_BITS - 1);
		cnt_next   = ctl_q.read_count;
		if (item.action == ACT_START) begin
			cnt_next  = '0;
			do_finish = 1'b1;
		end else begin
			case (ctl_q.last_kind)
				KIND_GENERAL: begin
					if (item.answer != ANS_NONE && item.answer != ANS_ONE) begin
						do_push  = 1'b1;
						set_tree = 1'b1;
					end else if (item.answer == ANS_ONE) begin
						do_read = 1'b1;
					end else begin
						do_finish = 1'b1;
					end
				end
				KIND_GROUP: begin
					if (item.answer == ANS_SEVERAL && top_q != '0) begin
						do_push  = 1'b1;
						push_lvl = top_q - LVL_W'(1);
					end else if (item.answer == ANS_ONE) begin
						do_read = 1'b1;
					end else begin
						do_advance = 1'b1;
					end
				end
				KIND_SINGLE: begin
					if (item.answer != ANS_NONE) begin
						cnt_next = cnt_inc;
					end
					do_advance = 1'b1;
				end
				KIND_READ: begin
					if (ctl_q.tree_active) begin
						if (item.answer != ANS_NONE) begin
							cnt_next = cnt_inc;
						end
						do_advance = 1'b1;
					end else begin
						cnt_next  = cnt_inc;
						do_finish = 1'b1;
					end
				end
				default: begin
					do_idle = 1'b1;
				end
			endcase
		end
		// A walk that has no branch left closes the tree.
		if (do_advance && !adv_found) begin
			do_advance = 1'b0;
			do_finish  = 1'b1;
		end
	end

	always_comb begin
		phase_d   = phase_q;
		top_d     = top_q;
		child_lvl = push_lvl;
		if (do_push) begin
			phase_d[push_lvl] = 1'b0;
			top_d             = push_lvl;
		end else if (do_advance) begin
			phase_d[adv_lvl] = 1'b1;
			top_d            = adv_lvl;
			child_lvl        = adv_lvl;
		end else if (do_finish) begin
			top_d = '0;
		end
	end

	// The prefix of a branch is its path from the root: the phase of each
	// level at or above it, placed least significant bit first.
	always_comb begin
		child_addr = '0;
		for (int i = 0; i < ADDR_W; i++) begin
			if (i < ADDRESS_BITS) begin
				child_addr[i] = phase_d[ADDRESS_BITS - 1 - i]
					&& (LVL_W'(ADDRESS_BITS - 1 - i) >= child_lvl);
			end
		end
	end

	always_comb begin
		result = '0;
		result.message_count = cnt_next;
		ctl_d            = ctl_q;
		ctl_d.read_count = cnt_next;
		if (set_tree) begin
			ctl_d.tree_active = 1'b1;
		end
		kind = KIND_IDLE;
		if (do_push || do_advance) begin
			if (child_lvl == '0) begin
				kind = KIND_SINGLE;
			end else begin
				kind         = KIND_GROUP;
				result.level = LEVEL_W'(child_lvl);
			end
			result.address = child_addr;
		end else if (do_read) begin
			kind = KIND_READ;
		end else if (do_finish) begin
			kind              = (cnt_next >= target) ? KIND_DONE : KIND_GENERAL;
			ctl_d.tree_active = 1'b0;
		end
		result.request_kind = kind;
		if (!do_idle) begin
			ctl_d.last_kind = kind;
		end
	end

endmodule
`default_nettype wire

// ----- verif/binary_tree_event_arbiter_core_tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for binary_tree_event_arbiter_core: partner answers go in,
// every request frame that comes out is checked against a behavioural tree walker.
// Depends on bta_pkg and the core module only.
module binary_tree_event_arbiter_core_tb;
	import bta_pkg::*;

	localparam int AB = ADDRESS_BITS_DEF;
	localparam logic [1:0] ANS_RESERVED = 2'd3;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	in_item_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	out_item_t out_data;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [COUNT_W-1:0] cfg_data = '0;

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int fail_count = 0;
	int sent_items = 0;

	// Walker state: prefix and branch side per tree level, plus the run state.
	logic [ADDR_W-1:0] walk_base [AB] = '{default: '0};
	logic walk_phase [AB] = '{default: 1'b0};
	int unsigned walk_top = 0;
	logic [KIND_W-1:0] prev_kind = KIND_IDLE;
	logic [COUNT_W-1:0] msg_count = '0;
	logic in_tree = 1'b0;
	logic [COUNT_W-1:0] goal_msgs = '0;

	out_item_t pending_requests [$];
	out_item_t predicted;

	binary_tree_event_arbiter_core #(.ADDRESS_BITS(AB)) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
	end

	function automatic out_item_t emit_req(logic [KIND_W-1:0] kind, int unsigned lvl,
			logic [ADDR_W-1:0] addr);
		out_item_t r;
		r.request_kind = kind;
		r.level = LEVEL_W'(lvl);
		r.address = addr;
		r.message_count = msg_count;
		if (kind != KIND_IDLE)
			prev_kind = kind;
		return r;
	endfunction

	function automatic int unsigned level_now();
		return (walk_top < AB) ? walk_top : AB - 1;
	endfunction

	function automatic logic [ADDR_W-1:0] child_addr(int unsigned m);
		logic [ADDR_W-1:0] a;
		a = walk_base[m];
		if (walk_phase[m])
			a[AB-1-m] = 1'b1;
		return a;
	endfunction

	function automatic out_item_t child_req();
		int unsigned m;
		m = level_now();
		if (m == 0)
			return emit_req(KIND_SINGLE, 0, child_addr(m));
		return emit_req(KIND_GROUP, m, child_addr(m));
	endfunction

	function automatic out_item_t descend(logic [ADDR_W-1:0] base, int unsigned lvl);
		walk_top = lvl;
		walk_base[lvl] = base;
		walk_phase[lvl] = 1'b0;
		return child_req();
	endfunction

	function automatic out_item_t close_tree();
		in_tree = 1'b0;
		walk_top = 0;
		if (msg_count >= goal_msgs)
			return emit_req(KIND_DONE, 0, '0);
		return emit_req(KIND_GENERAL, 0, '0);
	endfunction

	// Climb until a level still has its second branch to try; past the root the tree ends.
	function automatic out_item_t walk_on();
		int unsigned m;
		m = level_now();
		while (walk_phase[m] && m < AB - 1)
			m++;
		if (!walk_phase[m]) begin
			walk_phase[m] = 1'b1;
			walk_top = m;
			return child_req();
		end
		return close_tree();
	endfunction

	function automatic void bump_count();
		if (msg_count != '1)
			msg_count++;
	endfunction

	function automatic out_item_t predict_request(in_item_t it);
		int unsigned m;
		m = level_now();
		if (it.action == ACT_START) begin
			msg_count = '0;
			return close_tree();
		end
		case (prev_kind)
			KIND_GENERAL: begin
				if (it.answer >= ANS_SEVERAL) begin
					in_tree = 1'b1;
					return descend('0, AB - 1);
				end
				if (it.answer == ANS_ONE)
					return emit_req(KIND_READ, 0, '0);
				return close_tree();
			end
			KIND_GROUP: begin
				if (it.answer == ANS_SEVERAL && m > 0)
					return descend(child_addr(m), m - 1);
				if (it.answer == ANS_ONE)
					return emit_req(KIND_READ, 0, '0);
				return walk_on();
			end
			KIND_SINGLE: begin
				if (it.answer != ANS_NONE)
					bump_count();
				return walk_on();
			end
			KIND_READ: begin
				if (in_tree) begin
					if (it.answer != ANS_NONE)
						bump_count();
					return walk_on();
				end
				bump_count();
				return close_tree();
			end
			default: begin
				return emit_req(KIND_IDLE, 0, '0);
			end
		endcase
	endfunction

	task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			fail_count++;
		end
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_valid && cfg_ready)
				goal_msgs = cfg_data;
			if (in_valid && in_ready) begin
				predicted = predict_request(in_data);
				pending_requests.push_back(predicted);
				sent_items++;
			end
			if (out_valid && out_ready) begin
				if (pending_requests.size() == 0) begin
					$error("request frame arrived with no item outstanding");
					fail_count++;
				end else begin
					predicted = pending_requests.pop_front();
					check_field("request_kind", 16'(predicted.request_kind),
						16'(out_data.request_kind));
					check_field("level", 16'(predicted.level), 16'(out_data.level));
					check_field("address", 16'(predicted.address), 16'(out_data.address));
					check_field("message_count", predicted.message_count,
						out_data.message_count);
				end
			end
		end
	end

	task automatic send_bus_item(logic act, logic [1:0] ans);
		in_item_t it;
		it.action = act;
		it.answer = ans;
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= it;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
	endtask

	// Hold the sender back until every request frame has been seen.
	task automatic drain_results();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_requests.size() != 0)
			@(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic write_target(logic [COUNT_W-1:0] value);
		drain_results();
		cfg_valid <= 1'b1;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic test_answers_when_idle();
		send_bus_item(ACT_ANSWER, ANS_NONE);
		send_bus_item(ACT_ANSWER, ANS_RESERVED);
	endtask

	task automatic test_zero_target();
		write_target('0);
		send_bus_item(ACT_START, ANS_ONE);
		send_bus_item(ACT_ANSWER, ANS_SEVERAL);
	endtask

	// A read outside the tree counts even when the answer reports failure.
	task automatic test_single_message_run();
		write_target(16'd1);
		send_bus_item(ACT_START, ANS_NONE);
		send_bus_item(ACT_ANSWER, ANS_ONE);
		send_bus_item(ACT_ANSWER, ANS_NONE);
	endtask

	task automatic test_tree_walk();
		write_target(16'd3);
		send_bus_item(ACT_START, ANS_NONE);
		send_bus_item(ACT_ANSWER, ANS_RESERVED);
		send_bus_item(ACT_ANSWER, ANS_RESERVED);
		send_bus_item(ACT_ANSWER, ANS_SEVERAL);
		send_bus_item(ACT_ANSWER, ANS_ONE);
		send_bus_item(ACT_ANSWER, ANS_SEVERAL);
		// Restart in the middle of a tree, then dive straight down to the single requests.
		send_bus_item(ACT_START, ANS_SEVERAL);
		send_bus_item(ACT_ANSWER, ANS_SEVERAL);
		repeat (AB - 1) send_bus_item(ACT_ANSWER, ANS_SEVERAL);
		send_bus_item(ACT_ANSWER, ANS_ONE);
		send_bus_item(ACT_ANSWER, ANS_NONE);
	endtask

	task automatic test_random_traffic(int send_pct, int recv_pct, int n_items);
		int stop_at;
		int several_pct;
		int len;
		int r;
		logic [1:0] ans;
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
		write_target(16'($urandom_range(2, 12)));
		stop_at = sent_items + n_items;
		while (sent_items < stop_at) begin
			r = $urandom_range(0, 99);
			if (r < 12) begin
				case ($urandom_range(0, 4))
					0: write_target('0);
					1: write_target('1);
					2: write_target(16'($urandom_range(1, 8)));
					3: write_target(16'($urandom_range(1, 40)));
					default: write_target(16'($urandom));
				endcase
			end else if (r < 15) begin
				drain_results();
			end
			case ($urandom_range(0, 2))
				0: several_pct = 30;
				1: several_pct = 60;
				default: several_pct = 88;
			endcase
			len = $urandom_range(4, 60);
			if ($urandom_range(0, 9) != 0)
				send_bus_item(ACT_START, 2'($urandom_range(0, 3)));
			repeat (len) begin
				r = $urandom_range(0, 99);
				if (r < 4) begin
					send_bus_item(1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)));
				end else begin
					r = $urandom_range(0, 99);
					if (r < several_pct)
						ans = ANS_SEVERAL;
					else if (r < several_pct + (100 - several_pct) * 55 / 100)
						ans = ANS_NONE;
					else if (r < 96)
						ans = ANS_ONE;
					else
						ans = ANS_RESERVED;
					send_bus_item(ACT_ANSWER, ans);
				end
			end
		end
		drain_results();
	endtask

	// Climb the count with top-level reads under the largest target, then keep counting
	// inside a tree.
	task automatic test_count_climb();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		write_target('1);
		send_bus_item(ACT_START, ANS_NONE);
		repeat (20) begin
			send_bus_item(ACT_ANSWER, ANS_ONE);
			send_bus_item(ACT_ANSWER, ANS_ONE);
		end
		send_bus_item(ACT_ANSWER, ANS_SEVERAL);
		repeat (4) send_bus_item(ACT_ANSWER, ANS_ONE);
		send_bus_item(ACT_ANSWER, ANS_NONE);
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_answers_when_idle();
		test_zero_target();
		test_single_message_run();
		test_tree_walk();
		test_random_traffic(14, 80, 450);
		test_random_traffic(80, 14, 450);
		test_random_traffic(0, 0, 450);
		test_count_climb();
		drain_results();
		repeat (8) @(posedge clk);
		if (pending_requests.size() != 0) begin
			$error("%0d request frames never arrived", pending_requests.size());
			fail_count++;
		end
		if (fail_count == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

	initial begin
		#10_000_000;
		$display("Regression FAIL");
		$finish;
	end

endmodule

// ----- filelist.f -----
src/bta_pkg.sv
src/bta_step.sv
src/binary_tree_event_arbiter_core.sv
verif/binary_tree_event_arbiter_core_tb.sv
